>>> hw/rtl/fbpa_pkg.sv
// Shared types and codes of the fixed block pool allocator.
package fbpa_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_PAD   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd2;

	localparam logic [15:0] BLOCK_BYTES_RST = 16'd64;
	localparam logic [12:0] ALIGN_PAD_RST   = 13'd8;
	localparam logic [8:0]  BLOCK_COUNT_RST = 9'd256;

	typedef enum logic {
		CMD_ALLOC   = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		STS_OK         = 3'd0,
		STS_EMPTY      = 3'd1,
		STS_SIZE_BAD   = 3'd2,
		STS_ALIGN_BAD  = 3'd3,
		STS_NONE_ALLOC = 3'd4,
		STS_BAD_INDEX  = 3'd5,
		STS_NULL       = 3'd6
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_EXEC = 1'b1
	} fsm_t;

endpackage

>>> hw/rtl/fbpa_if.sv
// Request and response channel interfaces of the block pool allocator.
interface fbpa_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [15:0] request_size;
	logic [12:0] request_align;
	logic [7:0]  block_index;
	logic        is_null;

	modport source (output valid, command, request_size, request_align, block_index,
		is_null, input ready);
	modport sink (input valid, command, request_size, request_align, block_index,
		is_null, output ready);
endinterface

interface fbpa_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  granted_index;
	logic [24:0] byte_offset;
	logic [8:0]  live_count;
	logic [23:0] live_bytes;

	modport source (output valid, status, granted_index, byte_offset, live_count,
		live_bytes, input ready);
	modport sink (input valid, status, granted_index, byte_offset, live_count,
		live_bytes, output ready);
endinterface

>>> hw/rtl/fbpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/fixed_block_pool_allocator.sv
// An accepted request beat is captured and executed; its response goes to the output
// register. A new request is not taken until the previous one has been executed: the
// link memory read of the list head comes first, then the list read-modify-write.
// A response waiting in the output register holds the following request in execute
// until the response beat leaves; the beat after that waits at the input.
// Reset (arst_n low) empties the pool state and loads the register defaults; the link
// memory needs no clearing, so requests are taken as soon as reset is released.
module fixed_block_pool_allocator
	import fbpa_pkg::*;
#(
	parameter int MAX_BLOCKS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	fbpa_req_if.sink              req,
	fbpa_rsp_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int DEPTH = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [8:0] LIMIT = 9'(DEPTH);

	// configuration
	logic [15:0] block_bytes_q;
	logic [12:0] align_pad_q;
	logic [8:0]  block_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q <= BLOCK_BYTES_RST;
			align_pad_q   <= ALIGN_PAD_RST;
			block_count_q <= BLOCK_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BLOCK_BYTES: block_bytes_q <= cfg_wdata;
				CFG_ALIGN_PAD:   align_pad_q   <= cfg_wdata[12:0];
				CFG_BLOCK_COUNT: block_count_q <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	// pool state
	fsm_t        state_q, state_d;
	logic [7:0]  freed_head_q, freed_head_d;
	logic        freed_nonempty_q, freed_nonempty_d;
	logic [8:0]  fresh_next_q, fresh_next_d;
	logic [8:0]  alloc_total_q, alloc_total_d;
	logic [23:0] byte_total_q, byte_total_d;

	// request captured at acceptance
	cmd_t        cmd_s1;
	logic [15:0] req_size_s1;
	logic [12:0] req_align_s1;
	logic [7:0]  block_index_s1;
	logic        is_null_s1;

	// output register
	logic        rsp_valid_q;
	status_t     status_q, status_d;
	logic [7:0]  granted_q, granted_d;
	logic [24:0] offset_q, offset_d;

	logic        req_fire, exec_fire, slot_free;
	logic        mem_we;
	logic [7:0]  link_rdata;
	logic [8:0]  usable;
	logic [9:0]  alloc_inc;
	logic [16:0] slot_bytes;
	logic [24:0] byte_sum;
	logic [7:0]  pick_idx;

	fbpa_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (block_index_s1[AW-1:0]),
		.wdata (freed_head_q),
		.raddr (freed_head_q[AW-1:0]),
		.rdata (link_rdata)
	);

	assign req.ready  = (state_q == FSM_IDLE);
	assign req_fire   = req.valid && req.ready;
	assign slot_free  = !rsp_valid_q || rsp.ready;
	assign exec_fire  = (state_q == FSM_EXEC) && slot_free;

	assign usable     = (block_count_q > LIMIT) ? LIMIT : block_count_q;
	assign alloc_inc  = {1'b0, alloc_total_q} + 10'd1;
	assign slot_bytes = {1'b0, block_bytes_q} + {4'b0, align_pad_q};
	assign byte_sum   = {1'b0, byte_total_q} + {9'b0, block_bytes_q};

	always_comb begin
		state_d          = state_q;
		freed_head_d     = freed_head_q;
		freed_nonempty_d = freed_nonempty_q;
		fresh_next_d     = fresh_next_q;
		alloc_total_d    = alloc_total_q;
		byte_total_d     = byte_total_q;
		status_d         = STS_OK;
		granted_d        = '0;
		offset_d         = '0;
		pick_idx         = '0;
		mem_we           = 1'b0;

		unique case (state_q)
			FSM_IDLE: begin
				if (req_fire) begin
					state_d = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				if (cmd_s1 == CMD_ALLOC) begin
					priority if (req_size_s1 != block_bytes_q) begin
						status_d = STS_SIZE_BAD;
					end else if (req_align_s1 != align_pad_q) begin
						status_d = STS_ALIGN_BAD;
					end else if (freed_nonempty_q) begin
						// pop the released list; the link was read last cycle
						pick_idx         = freed_head_q;
						freed_nonempty_d = {1'b0, fresh_next_q} > alloc_inc;
						freed_head_d     = link_rdata;
					end else if (fresh_next_q < usable) begin
						pick_idx     = fresh_next_q[7:0];
						fresh_next_d = fresh_next_q + 9'd1;
					end else begin
						status_d = STS_EMPTY;
					end
					if (status_d == STS_OK) begin
						if (alloc_total_q != 9'h1ff) begin
							alloc_total_d = alloc_inc[8:0];
						end
						byte_total_d = byte_sum[24] ? 24'hff_ffff : byte_sum[23:0];
						granted_d    = pick_idx;
						offset_d     = {17'b0, pick_idx} * {8'b0, slot_bytes};
					end
				end else begin
					priority if (is_null_s1) begin
						status_d = STS_NULL;
					end else if (alloc_total_q == 9'd0) begin
						status_d = STS_NONE_ALLOC;
					end else if ({1'b0, block_index_s1} >= usable) begin
						status_d = STS_BAD_INDEX;
					end else begin
						// push on the head of the released list
						mem_we           = exec_fire;
						freed_head_d     = block_index_s1;
						freed_nonempty_d = 1'b1;
						alloc_total_d    = alloc_total_q - 9'd1;
						byte_total_d     = (byte_total_q >= {8'b0, block_bytes_q}) ?
							byte_total_q - {8'b0, block_bytes_q} : 24'd0;
					end
				end
				if (exec_fire) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= FSM_IDLE;
			freed_head_q     <= '0;
			freed_nonempty_q <= 1'b0;
			fresh_next_q     <= '0;
			alloc_total_q    <= '0;
			byte_total_q     <= '0;
			rsp_valid_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec_fire) begin
				freed_head_q     <= freed_head_d;
				freed_nonempty_q <= freed_nonempty_d;
				fresh_next_q     <= fresh_next_d;
				alloc_total_q    <= alloc_total_d;
				byte_total_q     <= byte_total_d;
				rsp_valid_q      <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_s1         <= cmd_t'(req.command);
			req_size_s1    <= req.request_size;
			req_align_s1   <= req.request_align;
			block_index_s1 <= req.block_index;
			is_null_s1     <= req.is_null;
		end
		if (exec_fire) begin
			status_q  <= status_d;
			granted_q <= granted_d;
			offset_q  <= offset_d;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.granted_index = granted_q;
	assign rsp.byte_offset   = offset_q;
	assign rsp.live_count    = alloc_total_q;
	assign rsp.live_bytes    = byte_total_q;

endmodule

>>> hw/rtl/fbpa_checker.sv
// Port-level checks of the block pool allocator, bound to the top level.
module fbpa_checker
	import fbpa_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  rsp_status,
	input logic [7:0]  rsp_granted_index,
	input logic [24:0] rsp_byte_offset
);

	// one request in flight: no beat is taken straight after another
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while the previous one is still in work");

	// a failed (non-ok) response carries no block
	a_fault_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != STS_OK) |-> (rsp_granted_index == 8'd0) &&
		(rsp_byte_offset == 25'd0))
		else $error("non-ok response carries a block index or offset");

	// hold a stalled response beat
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
		$stable(rsp_granted_index) && $stable(rsp_byte_offset))
		else $error("stalled response beat changed");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_granted_index (rsp.granted_index),
	.rsp_byte_offset   (rsp.byte_offset)
);
